### sv/ufd_pkg.sv
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps
package ufd_pkg;

	// code point constants
	localparam logic [20:0] REPL_CODE   = 21'h00FFFD;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
	localparam logic [20:0] MIN_LEN1    = 21'h000080;
	localparam logic [20:0] MIN_LEN2    = 21'h000800;
	localparam logic [20:0] MIN_LEN3    = 21'h010000;
	localparam logic [20:0] CTRL_LIMIT  = 21'd32;
	localparam logic [20:0] DEL_CODE    = 21'd127;

	// lead byte bounds
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [1:0] CONT_TAG = 2'b10;

	// sequence lengths in continuation bytes
	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_ONE  = 2'd1;
	localparam logic [1:0] SEQ_TWO  = 2'd2;
	localparam logic [1:0] SEQ_THREE = 2'd3;

	localparam logic [5:0] MAX_CHARS_RESET = 6'd32;
	localparam int         QUEUE_DEPTH_DEF = 4;

	// input beat
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic [20:0] code_point;
		logic        has_code;
		logic        end_of_string;
	} out_beat_t;

	// one queue entry: the one or two results caused by a byte
	typedef struct packed {
		logic      two;
		out_beat_t r0;
		out_beat_t r1;
	} pair_t;

endpackage

### sv/ufd_front.sv
// front end: accepts bytes, runs the utf-8 decode state and the per-string cap
`timescale 1ns / 1ps
module ufd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ufd_pkg::in_beat_t in_data,
	input  logic              cfg_wr_en,
	input  logic [5:0]        cfg_wr_data,
	input  logic              q_full,
	output logic              push,
	output ufd_pkg::pair_t    push_data
);
	import ufd_pkg::*;

	logic [20:0] part_q;
	logic [1:0]  br_q;
	logic [1:0]  len_q;
	logic [5:0]  cnt_q;
	logic [5:0]  max_chars_q;

	logic        accept;
	logic [7:0]  b;
	logic        is_cont, seq_open, brk, comp, do_fresh;
	logic        lead2, lead3, lead4, fresh_lead, fresh_emit;
	logic [20:0] shifted, fin_code, fresh_code, a_code;
	logic        a_v, b_v, c_v, ka, kb, kc, any_kept, two;
	logic [5:0]  cnt1, cnt2, cnt3;
	logic [20:0] part_d;
	logic [1:0]  br_d, len_d;
	logic [20:0] first_code, second_code;

	// overlong, surrogate and range check on a completed sequence
	function automatic logic [20:0] finish(input logic [20:0] code, input logic [1:0] len);
		logic bad;
		bad = (len == SEQ_ONE && code < MIN_LEN1) || (len == SEQ_TWO && code < MIN_LEN2) ||
			(len == SEQ_THREE && code < MIN_LEN3) ||
			(code >= SURR_LO && code <= SURR_HI) || (code > MAX_SCALAR);
		return bad ? REPL_CODE : code;
	endfunction

	// control codes are dropped
	function automatic logic printable(input logic [20:0] code);
		return !(code < CTRL_LIMIT || code == DEL_CODE);
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b        = in_data.byte_value;

	// classify the byte against the open sequence
	always_comb begin
		is_cont    = (b[7:6] == CONT_TAG);
		seq_open   = (br_q != SEQ_NONE);
		brk        = seq_open && !is_cont;
		comp       = seq_open && is_cont && (br_q == SEQ_ONE);
		do_fresh   = !seq_open || brk;
		shifted    = {part_q[14:0], b[5:0]};
		fin_code   = finish(shifted, len_q);
		lead2      = (b >= LEAD2_LO) && (b <= LEAD2_HI);
		lead3      = (b >= LEAD3_LO) && (b <= LEAD3_HI);
		lead4      = (b >= LEAD4_LO) && (b <= LEAD4_HI);
		fresh_lead = do_fresh && (lead2 || lead3 || lead4);
		fresh_emit = do_fresh && !(lead2 || lead3 || lead4);
		fresh_code = b[7] ? REPL_CODE : {13'd0, b};
	end

	// next sequence state
	always_comb begin
		part_d = '0;
		br_d   = SEQ_NONE;
		len_d  = SEQ_NONE;
		if (seq_open && is_cont && !comp) begin
			part_d = shifted;
			br_d   = br_q - 2'd1;
			len_d  = len_q;
		end else if (fresh_lead) begin
			if (lead2) begin
				part_d = {16'd0, b[4:0]};
				br_d   = SEQ_ONE;
			end else if (lead3) begin
				part_d = {17'd0, b[3:0]};
				br_d   = SEQ_TWO;
			end else begin
				part_d = {18'd0, b[2:0]};
				br_d   = SEQ_THREE;
			end
			len_d = br_d;
		end
	end

	// up to three candidate results, filtered by control codes and the cap
	always_comb begin
		a_v    = brk || comp;
		a_code = brk ? REPL_CODE : fin_code;
		b_v    = fresh_emit;
		c_v    = in_data.last_byte && (br_d != SEQ_NONE);
		ka     = a_v && printable(a_code) && (cnt_q < max_chars_q);
		cnt1   = cnt_q + {5'd0, ka};
		kb     = b_v && printable(fresh_code) && (cnt1 < max_chars_q);
		cnt2   = cnt1 + {5'd0, kb};
		kc     = c_v && (cnt2 < max_chars_q);
		cnt3   = cnt2 + {5'd0, kc};
		any_kept = ka || kb || kc;
		two      = (ka && kb) || (ka && kc) || (kb && kc);
		first_code  = ka ? a_code : (kb ? fresh_code : REPL_CODE);
		second_code = (ka && kb) ? fresh_code : REPL_CODE;
	end

	// pack the queue entry
	always_comb begin
		push_data.two              = two;
		push_data.r0.code_point    = any_kept ? first_code : 21'd0;
		push_data.r0.has_code      = any_kept;
		push_data.r0.end_of_string = in_data.last_byte && !two;
		push_data.r1.code_point    = second_code;
		push_data.r1.has_code      = 1'b1;
		push_data.r1.end_of_string = in_data.last_byte;
		push = accept && (any_kept || in_data.last_byte);
	end

	// decode state and cap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			br_q   <= SEQ_NONE;
			len_q  <= SEQ_NONE;
			cnt_q  <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				part_q <= '0;
				br_q   <= SEQ_NONE;
				len_q  <= SEQ_NONE;
				cnt_q  <= '0;
			end else begin
				part_q <= part_d;
				br_q   <= br_d;
				len_q  <= len_d;
				cnt_q  <= cnt3;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RESET;
		end else if (cfg_wr_en) begin
			max_chars_q <= cfg_wr_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(br_q == SEQ_NONE) |-> (part_q == '0 && len_q == SEQ_NONE))
		else $error("closed sequence left partial state");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.last_byte) |=> (cnt_q == '0 && br_q == SEQ_NONE))
		else $error("string end did not clear state");
`endif

endmodule

### sv/ufd_queue.sv
// short queue of decoded result pairs between front and back
`timescale 1ns / 1ps
module ufd_queue #(
	parameter int DEPTH = ufd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ufd_pkg::pair_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output ufd_pkg::pair_t head_data
);
	import ufd_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pair_t             entries_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !do_push)
		else $error("push into full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= FULL_CNT))
		else $error("queue count out of range");
`endif

endmodule

### sv/ufd_back.sv
// back end: unpacks result pairs into single output beats behind a register
`timescale 1ns / 1ps
module ufd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ufd_pkg::pair_t    head_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output ufd_pkg::out_beat_t out_data
);
	import ufd_pkg::*;

	logic      out_valid_q;
	out_beat_t out_q;
	logic      pend_valid_q;
	out_beat_t pend_q;
	logic      load;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && !pend_valid_q && head_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// output register, held second result first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= head_valid;
				pend_valid_q <= head_valid && head_data.two;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (head_valid) begin
				out_q  <= head_data.r0;
				pend_q <= head_data.r1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("held result without a beat in the output register");
`endif

endmodule

### sv/utf8_stream_decoder_top.sv
// utf-8 stream decoder: decode state and cap in front, result queue, beat unpacker behind
// path: the first result of an accepted byte is written into the result queue and then registered for out_data
// throughput: one byte per cycle while in_stall is low and one output beat per cycle while out_stall is low;
//   a byte that gives two results sends them as two output beats, absorbed by the result queue
// in_stall rises only when the result queue is full
// reset: arst_n clears decode state, queue and output valid at once; max_chars returns to 32
`timescale 1ns / 1ps
module utf8_stream_decoder_top #(
	parameter int QUEUE_DEPTH = ufd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ufd_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ufd_pkg::out_beat_t out_data,
	input  logic               cfg_wr_en,
	input  logic [5:0]         cfg_wr_data
);
	import ufd_pkg::*;

	logic  q_full, push, pop, head_valid;
	pair_t push_data, head_data;

	// byte decode and classify
	ufd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	// result queue
	ufd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// output beats
	ufd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### tb/tb_utf8_stream_decoder_top.sv
// self-checking testbench for the utf-8 stream decoder: directed table, random strings, cap settings
`timescale 1ns / 1ps
module tb_utf8_stream_decoder_top;
	import ufd_pkg::*;

	localparam int ITEM_GOAL   = 750;
	localparam int PHASE_BYTES = 110;
	localparam int LONG_HOLD   = 80;
	localparam int DRAIN_WAIT  = 12;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 40;

	localparam logic [7:0] LEAD_PREFIX2 = 8'hC0;
	localparam logic [7:0] LEAD_PREFIX3 = 8'hE0;
	localparam logic [7:0] LEAD_PREFIX4 = 8'hF0;
	localparam logic [7:0] CONT_PREFIX  = 8'h80;
	localparam logic [7:0] CONT_HI      = 8'hBF;
	localparam logic [7:0] ASCII_LIMIT  = 8'h80;

	localparam out_beat_t NO_BEAT  = '0;
	localparam out_beat_t END_ONLY = '{21'd0, 1'b0, 1'b1};

	// one directed row; want is used only when typed is set
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
		logic       typed;
		out_beat_t  want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_beat_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_beat_t          out_data;
	logic               cfg_wr_en = 1'b0;
	logic [5:0]         cfg_wr_data = '0;

	// decoder shadow state
	logic [20:0] seq_code = '0;
	logic [1:0]  cont_left = SEQ_NONE;
	logic [1:0]  cont_total = SEQ_NONE;
	logic [5:0]  char_count = '0;
	logic [5:0]  cap_limit = MAX_CHARS_RESET;

	out_beat_t   step_out[$];
	out_beat_t   pending_codes[$];
	logic [7:0]  text_bytes[$];

	int  cycle_count = 0;
	int  mismatches = 0;
	int  results_checked = 0;
	int  bytes_sent = 0;
	int  strings_sent = 0;
	int  caps_written = 0;
	bit  no_idle = 1'b0;
	bit  hold_req = 1'b0;

	// extremes, every lead class, overlong, surrogate, broken and truncated sequences
	dir_row_t dir_rows [24] = '{
		'{8'h41, 1'b0, 1'b1, '{21'h000041, 1'b1, 1'b0}},
		'{8'h00, 1'b0, 1'b0, NO_BEAT},
		'{8'h7F, 1'b1, 1'b1, END_ONLY},
		'{8'hFF, 1'b0, 1'b1, '{REPL_CODE, 1'b1, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{REPL_CODE, 1'b1, 1'b0}},
		'{8'hC1, 1'b0, 1'b1, '{REPL_CODE, 1'b1, 1'b0}},
		'{8'hC2, 1'b0, 1'b0, NO_BEAT},
		'{8'h80, 1'b0, 1'b0, NO_BEAT},
		'{8'hE0, 1'b0, 1'b0, NO_BEAT},
		'{8'h80, 1'b0, 1'b0, NO_BEAT},
		'{8'h80, 1'b0, 1'b1, '{REPL_CODE, 1'b1, 1'b0}},
		'{8'hED, 1'b0, 1'b0, NO_BEAT},
		'{8'hA0, 1'b0, 1'b0, NO_BEAT},
		'{8'h80, 1'b0, 1'b1, '{REPL_CODE, 1'b1, 1'b0}},
		'{8'hF4, 1'b0, 1'b0, NO_BEAT},
		'{8'h8F, 1'b0, 1'b0, NO_BEAT},
		'{8'hBF, 1'b0, 1'b0, NO_BEAT},
		'{8'hBF, 1'b0, 1'b1, '{MAX_SCALAR, 1'b1, 1'b0}},
		'{8'hE2, 1'b0, 1'b0, NO_BEAT},
		'{8'h41, 1'b0, 1'b0, NO_BEAT},
		'{8'hE2, 1'b0, 1'b0, NO_BEAT},
		'{8'h82, 1'b1, 1'b1, '{REPL_CODE, 1'b1, 1'b1}},
		'{8'hDF, 1'b0, 1'b0, NO_BEAT},
		'{8'hBF, 1'b1, 1'b0, NO_BEAT}
	};

	utf8_stream_decoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// drop a code point if it is a control, past the cap, or a third result
	function automatic void emit_code(input logic [20:0] code);
		if (code < CTRL_LIMIT || code == DEL_CODE)
			return;
		if (char_count >= cap_limit)
			return;
		if (step_out.size() >= 2)
			return;
		step_out.insert(step_out.size(), out_beat_t'{code, 1'b1, 1'b0});
		char_count = char_count + 6'd1;
	endfunction

	function automatic void drop_sequence();
		seq_code = '0;
		cont_left = SEQ_NONE;
		cont_total = SEQ_NONE;
	endfunction

	// overlong, surrogate and out-of-range values become the replacement
	function automatic logic [20:0] checked_code(input logic [20:0] code, input logic [1:0] conts);
		if ((conts == SEQ_ONE && code < MIN_LEN1) || (conts == SEQ_TWO && code < MIN_LEN2) ||
		    (conts == SEQ_THREE && code < MIN_LEN3) ||
		    (code >= SURR_LO && code <= SURR_HI) || code > MAX_SCALAR)
			return REPL_CODE;
		return code;
	endfunction

	// byte seen with no open sequence
	function automatic void start_byte(input logic [7:0] value);
		if (value < ASCII_LIMIT) begin
			emit_code({13'd0, value});
		end else if (value >= LEAD2_LO && value <= LEAD2_HI) begin
			seq_code = {16'd0, value[4:0]};
			cont_left = SEQ_ONE;
			cont_total = SEQ_ONE;
		end else if (value >= LEAD3_LO && value <= LEAD3_HI) begin
			seq_code = {17'd0, value[3:0]};
			cont_left = SEQ_TWO;
			cont_total = SEQ_TWO;
		end else if (value >= LEAD4_LO && value <= LEAD4_HI) begin
			seq_code = {18'd0, value[2:0]};
			cont_left = SEQ_THREE;
			cont_total = SEQ_THREE;
		end else begin
			emit_code(REPL_CODE);
		end
	endfunction

	// expected results of one accepted byte, left in step_out
	function automatic void decode_byte(input in_beat_t beat);
		logic [20:0] code;
		step_out.delete();
		if (cont_left != SEQ_NONE) begin
			if (beat.byte_value[7:6] == CONT_TAG) begin
				seq_code = {seq_code[14:0], beat.byte_value[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == SEQ_NONE) begin
					code = checked_code(seq_code, cont_total);
					drop_sequence();
					emit_code(code);
				end
			end else begin
				// broken sequence: replacement, then the byte starts over
				drop_sequence();
				emit_code(REPL_CODE);
				start_byte(beat.byte_value);
			end
		end else begin
			start_byte(beat.byte_value);
		end
		if (beat.last_byte) begin
			if (cont_left != SEQ_NONE) begin
				drop_sequence();
				emit_code(REPL_CODE);
			end
			if (step_out.size() == 0)
				step_out.insert(0, END_ONLY);
			else
				step_out[step_out.size() - 1].end_of_string = 1'b1;
			drop_sequence();
			char_count = '0;
		end
	endfunction

	function automatic int rand_gap();
		int pick;
		if (no_idle)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		if (pending_codes.size() == 0) begin
			flag_mismatch($sformatf("unexpected beat cp=%h has=%b end=%b",
				got.code_point, got.has_code, got.end_of_string));
			return;
		end
		want = pending_codes.pop_front();
		results_checked++;
		if (got.code_point !== want.code_point)
			flag_mismatch($sformatf("code_point %h, want %h", got.code_point, want.code_point));
		if (got.has_code !== want.has_code)
			flag_mismatch($sformatf("has_code %b, want %b", got.has_code, want.has_code));
		if (got.end_of_string !== want.end_of_string)
			flag_mismatch($sformatf("end_of_string %b, want %b (cp %h)",
				got.end_of_string, want.end_of_string, want.code_point));
	endtask

	// offer one byte beat and wait until it is taken
	task automatic send_beat(input logic [7:0] value, input logic last, input logic typed,
	                         input out_beat_t want);
		int gap;
		in_beat_t beat;
		beat.byte_value = value;
		beat.last_byte = last;
		gap = rand_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		decode_byte(beat);
		if (typed)
			pending_codes.insert(pending_codes.size(), want);
		else
			foreach (step_out[i]) pending_codes.insert(pending_codes.size(), step_out[i]);
		bytes_sent++;
		if (last)
			strings_sent++;
	endtask

	// lead plus continuations, with the last drop continuations left off
	task automatic put_encoded(input logic [20:0] cp, input int conts, input int drop);
		logic [7:0] lead;
		case (conts)
			1: begin
				lead = LEAD_PREFIX2 | 8'(cp >> 6);
			end
			2: begin
				lead = LEAD_PREFIX3 | 8'(cp >> 12);
			end
			default: begin
				lead = LEAD_PREFIX4 | 8'(cp >> 18);
			end
		endcase
		text_bytes.insert(text_bytes.size(), lead);
		for (int i = conts - 1; i >= drop; i--)
			text_bytes.insert(text_bytes.size(),
				CONT_PREFIX | (8'(cp >> (6 * i)) & 8'h3F));
	endtask

	function automatic logic [20:0] rand_scalar(input int conts);
		case (conts)
			1: return 21'($urandom_range(MIN_LEN1, MIN_LEN2 - 1));
			2: return 21'($urandom_range(MIN_LEN2, MIN_LEN3 - 1));
			default: return 21'($urandom_range(MIN_LEN3, MAX_SCALAR));
		endcase
	endfunction

	// append one character, mostly well formed
	task automatic add_char();
		int kind;
		int conts;
		logic [20:0] cp;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			text_bytes.insert(text_bytes.size(),
				8'($urandom_range(CTRL_LIMIT, DEL_CODE - 1)));
		end else if (kind < 35) begin
			if ($urandom_range(0, 4) == 0)
				text_bytes.insert(text_bytes.size(), DEL_CODE[7:0]);
			else
				text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, CTRL_LIMIT - 1)));
		end else if (kind < 75) begin
			conts = (kind < 50) ? 1 : (kind < 65) ? 2 : 3;
			cp = rand_scalar(conts);
			if (cp >= SURR_LO && cp <= SURR_HI)
				cp = cp ^ 21'h008000;
			put_encoded(cp, conts, 0);
		end else if (kind < 80) begin
			// overlong form
			conts = $urandom_range(1, 3);
			cp = 21'($urandom_range(0, (conts == 1) ? MIN_LEN1 - 1 :
				(conts == 2) ? MIN_LEN2 - 1 : MIN_LEN3 - 1));
			put_encoded(cp, conts, 0);
		end else if (kind < 84) begin
			put_encoded(21'($urandom_range(SURR_LO, SURR_HI)), 2, 0);
		end else if (kind < 87) begin
			put_encoded(21'($urandom_range(MAX_SCALAR + 1, 21'h13FFFF)), 3, 0);
		end else if (kind < 92) begin
			conts = $urandom_range(1, 3);
			put_encoded(rand_scalar(conts), conts, $urandom_range(1, conts));
		end else if (kind < 96) begin
			text_bytes.insert(text_bytes.size(), 8'($urandom_range(CONT_PREFIX, CONT_HI)));
		end else begin
			text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_string(input int nchars);
		text_bytes.delete();
		repeat (nchars) add_char();
		foreach (text_bytes[i])
			send_beat(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_BEAT);
	endtask

	// wait for every expected beat, then let the pipeline empty
	task automatic settle();
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_cap(input logic [5:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cap_limit = value;
		cfg_wr_en <= 1'b0;
		caps_written++;
	endtask

	// receiver: checks accepted beats and drives stall, with one long hold on request
	initial begin
		int hold_left;
		int run_left;
		logic stall_next;
		hold_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_result(out_data);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (run_left != 0) begin
				run_left--;
				stall_next = 1'b0;
			end else begin
				hold_left = rand_gap();
				run_left = no_idle ? 30 : $urandom_range(0, 12);
				stall_next = (hold_left != 0);
				if (hold_left != 0)
					hold_left--;
			end
			out_stall <= stall_next;
		end
	end

	// stimulus
	initial begin
		int phase;
		int phase_start;
		int nchars;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset cap
		foreach (dir_rows[i])
			send_beat(dir_rows[i].byte_value, dir_rows[i].last_byte, dir_rows[i].typed,
				dir_rows[i].want);
		in_valid <= 1'b0;

		// random strings, one cap setting per phase
		phase = 0;
		while (bytes_sent < ITEM_GOAL + $size(dir_rows)) begin
			settle();
			case (phase)
				0: begin
					set_cap(6'd0);
				end
				1: begin
					set_cap(6'd63);
				end
				2: begin
					set_cap(6'd1);
				end
				default: begin
					set_cap(6'($urandom_range(0, 63)));
				end
			endcase
			no_idle = (phase % 4 == 3);
			if (phase == 3)
				hold_req = 1'b1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				if (bytes_sent == phase_start && (phase == 1 || phase == 3))
					nchars = 80;
				else if ($urandom_range(0, 9) == 0)
					nchars = $urandom_range(64, 90);
				else
					nchars = $urandom_range(1, 10);
				send_string(nchars);
			end
			in_valid <= 1'b0;
			no_idle = 1'b0;
			phase++;
		end
		settle();

		$display("covered %0d bytes in %0d strings under %0d cap writes (0, 63, 1 and random)",
			bytes_sent, strings_sent, caps_written);
		$display("%0d result beats checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
sv/ufd_pkg.sv
sv/ufd_front.sv
sv/ufd_queue.sv
sv/ufd_back.sv
sv/utf8_stream_decoder_top.sv
tb/tb_utf8_stream_decoder_top.sv
